// ----- hw/rtl/directional_focus_search_defines.svh -----
// Assertion macros for the directional focus search block.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef DIRECTIONAL_FOCUS_SEARCH_DEFINES_SVH
`define DIRECTIONAL_FOCUS_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DFS_ASSERT_SAME(lbl, ante, cons)
`define DFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/dfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int COORD_W      = 16;
    localparam int COST_W       = 18;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One stored element: eligibility flag and rectangle.
    typedef struct packed {
        logic   flag;
        t_coord x0;
        t_coord x1;
        t_coord y0;
        t_coord y1;
    } t_elem;

    // Search context held for the whole scan.
    typedef struct packed {
        t_coord           x0;
        t_coord           x1;
        t_coord           y0;
        t_coord           y1;
        t_coord           cx;
        t_coord           cy;
        t_dir             dir;
        logic             has_focus;
        logic [IDX_W-1:0] skip;
    } t_focus;

    // One scored candidate leaving the cost stage.
    typedef struct packed {
        logic              valid;
        logic              qual;
        logic [IDX_W-1:0]  idx;
        logic [COST_W-1:0] cost;
    } t_cand;

    // Midpoint of two coordinates, rounded toward zero.
    function automatic t_coord centre(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        s = s + {{COORD_W{1'b0}}, s[COORD_W]};
        return s[COORD_W:1];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dfs_elem_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dfs_elem_ram import dfs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_elem            i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic                  o_rd_valid,
    output logic [IDX_W-1:0]      o_rd_idx,
    output t_elem                 o_rd_data
);

    t_elem            r_mem [MAX_ELEMENTS];
    t_elem            r_rd_data;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
        r_rd_idx  <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_re;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_idx   = r_rd_idx;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

// ----- hw/rtl/dfs_cost_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dfs_cost_unit import dfs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_focus           i_focus,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_elem            i_elem,
    output t_cand                 o_cand
);

    // Distance between ranges [a0,a1] and [b0,b1], zero when they overlap.
    function automatic logic [COORD_W-1:0] range_gap(input t_coord a0, input t_coord a1,
                                                     input t_coord b0, input t_coord b1);
        logic signed [COORD_W:0] d1;
        logic signed [COORD_W:0] d2;
        d1 = {b0[COORD_W-1], b0} - {a1[COORD_W-1], a1};
        d2 = {a0[COORD_W-1], a0} - {b1[COORD_W-1], b1};
        if (d1 > 0) begin
            return d1[COORD_W-1:0];
        end else if (d2 > 0) begin
            return d2[COORD_W-1:0];
        end
        return '0;
    endfunction

    t_coord                  ex;
    t_coord                  ey;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W+1:0] along;
    logic [COORD_W-1:0]      gap;
    logic                    along_pos;
    logic                    rect_ok;
    logic                    skipped;
    logic [COST_W-1:0]       cost;
    t_cand                   r_cand;

    always_comb begin
        ex = centre(i_elem.x0, i_elem.x1);
        ey = centre(i_elem.y0, i_elem.y1);
        dx = {ex[COORD_W-1], ex} - {i_focus.cx[COORD_W-1], i_focus.cx};
        dy = {ey[COORD_W-1], ey} - {i_focus.cy[COORD_W-1], i_focus.cy};
        case (i_focus.dir)
            DIR_UP: begin
                along = -{dy[COORD_W], dy};
                gap   = range_gap(i_focus.x0, i_focus.x1, i_elem.x0, i_elem.x1);
            end
            DIR_DOWN: begin
                along = {dy[COORD_W], dy};
                gap   = range_gap(i_focus.x0, i_focus.x1, i_elem.x0, i_elem.x1);
            end
            DIR_LEFT: begin
                along = -{dx[COORD_W], dx};
                gap   = range_gap(i_focus.y0, i_focus.y1, i_elem.y0, i_elem.y1);
            end
            default: begin
                along = {dx[COORD_W], dx};
                gap   = range_gap(i_focus.y0, i_focus.y1, i_elem.y0, i_elem.y1);
            end
        endcase
        along_pos = !along[COORD_W+1] && (along != '0);
        rect_ok   = (i_elem.x1 > i_elem.x0) && (i_elem.y1 > i_elem.y0);
        skipped   = i_focus.has_focus && (i_idx == i_focus.skip);
        // Along is positive here whenever the result is used, so its low bits are the value.
        cost      = along[COST_W-1:0] + {1'b0, gap, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= i_valid;
        end
        r_cand.qual <= i_elem.flag && rect_ok && !skipped && along_pos;
        r_cand.idx  <= i_idx;
        r_cand.cost <= cost;
    end

    assign o_cand = r_cand;

endmodule

`default_nettype wire

// ----- hw/rtl/directional_focus_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "directional_focus_search_defines.svh"

// Directional focus search. Clear and append beats finish in the cycle they are
// accepted and produce no result; an append to a full list of 64 entries is dropped.
// A search beat walks the stored elements through the single read port of the
// element memory, one entry per cycle, followed by a scoring stage and a compare
// stage, and then yields one result beat (found, index, cost). The input is not
// ready during a search. A finished result waits in the output register while the
// next beat is accepted; a following search holds its result until that register is
// free, and the input stays not ready for as long as it waits.
// The origin registers may be written only while the block is idle.
module directional_focus_search import dfs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_wdata,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_op,
    input  wire logic signed [15:0]   i_left_edge,
    input  wire logic signed [15:0]   i_right_edge,
    input  wire logic signed [15:0]   i_top_edge,
    input  wire logic signed [15:0]   i_bottom_edge,
    input  wire logic                 i_eligible,
    input  wire logic [1:0]           i_direction,
    input  wire logic                 i_has_focus,
    input  wire logic [5:0]           i_focus_index,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_found,
    output logic [5:0]                o_best_index,
    output logic [17:0]               o_best_cost
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state            r_state;
    t_coord            r_origin_x;
    t_coord            r_origin_y;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_scan;
    t_focus            r_focus;
    logic              r_best_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [COST_W-1:0] r_best_cost;
    logic              r_out_valid;
    logic              r_out_found;
    logic [IDX_W-1:0]  r_out_idx;
    logic [COST_W-1:0] r_out_cost;

    t_op               op;
    logic              accept;
    logic              wr_en;
    t_elem             wr_elem;
    logic              rd_en;
    logic              rd_valid;
    logic [IDX_W-1:0]  rd_idx;
    t_elem             rd_elem;
    t_cand             cand;
    logic [CNT_W-1:0]  last_cnt;
    logic              scan_last;

    assign op      = t_op'(i_op);
    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    assign wr_en   = accept && (op == OP_APPEND) && (r_count < CNT_W'(MAX_ELEMENTS));
    assign wr_elem = '{flag: i_eligible, x0: i_left_edge, x1: i_right_edge,
                       y0: i_top_edge, y1: i_bottom_edge};

    assign rd_en     = (r_state == ST_SCAN);
    assign last_cnt  = r_count - CNT_W'(1);
    assign scan_last = (r_scan == last_cnt[IDX_W-1:0]);

    dfs_elem_ram u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (wr_en),
        .i_waddr    (r_count[IDX_W-1:0]),
        .i_wdata    (wr_elem),
        .i_re       (rd_en),
        .i_raddr    (r_scan),
        .o_rd_valid (rd_valid),
        .o_rd_idx   (rd_idx),
        .o_rd_data  (rd_elem)
    );

    dfs_cost_unit u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_focus (r_focus),
        .i_valid (rd_valid),
        .i_idx   (rd_idx),
        .i_elem  (rd_elem),
        .o_cand  (cand)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_origin_x   <= 16'sd320;
            r_origin_y   <= 16'sd240;
            r_count      <= '0;
            r_scan       <= '0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ORIGIN_X: r_origin_x <= i_cfg_wdata;
                    CFG_ORIGIN_Y: r_origin_y <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // The finish state reloads the output register itself.
            if (r_out_valid && i_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            // Running minimum; a tie keeps the earlier element.
            if (cand.valid && cand.qual && (!r_best_found || cand.cost < r_best_cost)) begin
                r_best_found <= 1'b1;
                r_best_idx   <= cand.idx;
                r_best_cost  <= cand.cost;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (op)
                            OP_CLEAR: r_count <= '0;
                            OP_APPEND: begin
                                if (wr_en) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_SEARCH: begin
                                r_scan       <= '0;
                                r_best_found <= 1'b0;
                                r_best_idx   <= '0;
                                r_best_cost  <= '0;
                                r_state      <= (r_count == '0) ? ST_DRAIN : ST_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_scan <= r_scan + IDX_W'(1);
                    if (scan_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rd_valid && !cand.valid) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_best_found;
                        r_out_idx   <= r_best_found ? r_best_idx : '0;
                        r_out_cost  <= r_best_found ? r_best_cost : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Search context: the focused rectangle, or a point at the configured origin.
    always_ff @(posedge i_clk) begin
        if (accept && (op == OP_SEARCH)) begin
            r_focus.dir       <= t_dir'(i_direction);
            r_focus.has_focus <= i_has_focus;
            r_focus.skip      <= i_focus_index;
            if (i_has_focus) begin
                r_focus.x0 <= i_left_edge;
                r_focus.x1 <= i_right_edge;
                r_focus.y0 <= i_top_edge;
                r_focus.y1 <= i_bottom_edge;
                r_focus.cx <= centre(i_left_edge, i_right_edge);
                r_focus.cy <= centre(i_top_edge, i_bottom_edge);
            end else begin
                r_focus.x0 <= r_origin_x;
                r_focus.x1 <= r_origin_x;
                r_focus.y0 <= r_origin_y;
                r_focus.y1 <= r_origin_y;
                r_focus.cx <= r_origin_x;
                r_focus.cy <= r_origin_y;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_best_index = r_out_idx;
    assign o_best_cost  = r_out_cost;

    `DFS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ELEMENTS))
    `DFS_ASSERT_SAME(a_found_cost, o_valid && o_found, o_best_cost != '0)
    `DFS_ASSERT_SAME(a_none_zero, o_valid && !o_found, o_best_index == '0 && o_best_cost == '0)
    `DFS_ASSERT_NEXT(a_search_busy, i_valid && o_ready && i_op == OP_SEARCH, !o_ready)

endmodule

`default_nettype wire
